// ===== design/ard_pkg.sv =====
package ard_pkg;

    localparam int unsigned NUM_COLUMNS = 4;
    localparam logic [3:0] BLANK_CODE = 4'd10;
    localparam logic [11:0] REST_OFFSET = 12'd2000;
    localparam logic [1:0] COL_TENS = 2'd0;
    localparam logic [1:0] COL_HUNDREDS = 2'd1;
    localparam logic [1:0] COL_THOUSANDS = 2'd2;
    localparam logic [1:0] COL_TEN_THOUSANDS = 2'd3;
    localparam int unsigned IN_TDATA_W = 16;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef struct packed {
        logic       last_column;
        logic [3:0] digit_below;
        logic [3:0] digit_middle;
        logic [3:0] digit_above;
        logic [11:0] scroll_offset;
        logic [1:0] column;
    } result_t;

    typedef result_t result_set_t [NUM_COLUMNS];

    // ((step*61)/4 + 1000) * 2
    function automatic logic [11:0] offset_fine(input logic [3:0] step);
        logic [9:0]  prod;
        logic [10:0] sum;
        prod = {6'd0, step} * 10'd61;
        sum  = {3'd0, prod[9:2]} + 11'd1000;
        return {sum, 1'b0};
    endfunction

    // ((step*6)/4 + 1000) * 2
    function automatic logic [11:0] offset_coarse(input logic [6:0] step);
        logic [9:0]  prod;
        logic [10:0] sum;
        prod = {3'd0, step} * 10'd6;
        sum  = {3'd0, prod[9:2]} + 11'd1000;
        return {sum, 1'b0};
    endfunction

    function automatic logic [3:0] digit_code(input logic [3:0] digit, input logic [1:0] row,
                                              input logic blank_zero);
        logic [3:0] d;
        case (row)
            2'd0:    d = (digit == 4'd0) ? 4'd9 : digit - 4'd1;
            2'd2:    d = (digit == 4'd9) ? 4'd0 : digit + 4'd1;
            default: d = digit;
        endcase
        return (blank_zero && d == 4'd0) ? BLANK_CODE : d;
    endfunction

    function automatic result_t make_result(input logic [1:0] col, input logic [11:0] offset,
                                            input logic [3:0] digit, input logic blank_zero);
        result_t r;
        r.column        = col;
        r.scroll_offset = offset;
        r.digit_above   = digit_code(digit, 2'd0, blank_zero);
        r.digit_middle  = digit_code(digit, 2'd1, blank_zero);
        r.digit_below   = digit_code(digit, 2'd2, blank_zero);
        r.last_column   = (col == COL_TEN_THOUSANDS);
        return r;
    endfunction

endpackage

// ===== design/ard_decode.sv =====
module ard_decode
    import ard_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [14:0] altitude_code,
    output logic        res_valid,
    input  logic        res_ready,
    output result_set_t res
);

    logic        valid_reg;
    logic [14:0] alt_reg;

    logic [2:0]  frac;
    logic [11:0] n;
    logic [24:0] prod_q1;
    logic [23:0] prod_qh;
    logic [24:0] prod_qk;
    logic [8:0]  q1;
    logic [5:0]  qh;
    logic [2:0]  qk;
    logic [11:0] d1_wide;
    logic [8:0]  d2_wide;
    logic [5:0]  d3_wide;
    logic [3:0]  d1, d2, d3, d4;
    logic [6:0]  pos;
    logic [3:0]  k_fine;
    logic [6:0]  k_coarse;
    logic [11:0] off_roll;
    logic [11:0] off_pos;
    logic        low_regime;

    assign in_ready  = !valid_reg || res_ready;
    assign res_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            alt_reg <= altitude_code;
        end
    end

    // decimal digits by reciprocal multiply, exact for n < 4096
    always_comb
    begin
        frac    = alt_reg[2:0];
        n       = alt_reg[14:3];
        prod_q1 = {13'd0, n} * 25'd6554;
        prod_qh = {12'd0, n} * 24'd2622;
        prod_qk = {13'd0, n} * 25'd4195;
        q1      = prod_q1[24:16];
        qh      = prod_qh[23:18];
        qk      = prod_qk[24:22];
        d1_wide = n - ({3'd0, q1} * 12'd10);
        d2_wide = q1 - ({3'd0, qh} * 9'd10);
        d3_wide = qh - ({3'd0, qk} * 6'd10);
        d1      = d1_wide[3:0];
        d2      = d2_wide[3:0];
        d3      = d3_wide[3:0];
        d4      = {1'b0, qk};
        low_regime = (n < 12'd100);
        pos     = {d1[3:0], frac};

        k_fine   = (frac >= 3'd6) ? 4'd8 : {frac - 3'd2, 1'b0};
        k_coarse = (pos >= 7'd64) ? 7'd80 : {pos[5:0] - 6'd24, 1'b0};

        if (low_regime)
        begin
            off_pos  = offset_fine({1'b0, frac});
            off_roll = (frac > 3'd2 && d1 == 4'd9) ? offset_fine(k_fine) : REST_OFFSET;
            res[0] = make_result(COL_TENS, off_pos, d1, 1'b0);
            res[1] = make_result(COL_HUNDREDS, off_roll, d2, n < 12'd10);
            res[2] = make_result(COL_THOUSANDS, (d2 == 4'd9) ? off_roll : REST_OFFSET,
                                 d3, 1'b1);
            res[3] = make_result(COL_TEN_THOUSANDS, REST_OFFSET, 4'd0, 1'b0);
            res[3].digit_above  = BLANK_CODE;
            res[3].digit_middle = BLANK_CODE;
            res[3].digit_below  = BLANK_CODE;
        end
        else
        begin
            off_pos  = offset_coarse(pos);
            off_roll = (pos > 7'd24 && d2 == 4'd9) ? offset_coarse(k_coarse) : REST_OFFSET;
            res[0] = make_result(COL_TENS, off_pos, 4'd0, 1'b0);
            res[0].digit_above = 4'd0;
            res[0].digit_below = 4'd0;
            res[1] = make_result(COL_HUNDREDS, off_pos, d2, 1'b0);
            res[2] = make_result(COL_THOUSANDS, off_roll, d3, 1'b0);
            res[3] = make_result(COL_TEN_THOUSANDS, (d3 == 4'd9) ? off_roll : REST_OFFSET,
                                 d4, n < 12'd1000);
        end
    end

endmodule

// ===== design/ard_emit.sv =====
module ard_emit
    import ard_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    output logic        res_ready,
    input  result_set_t res,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_item
);

    logic        valid_reg;
    result_t     buf_reg [NUM_COLUMNS];
    logic        out_fire;
    logic        load;

    assign out_fire  = valid_reg && out_ready;
    assign res_ready = !valid_reg || (out_fire && buf_reg[0].last_column);
    assign load      = res_ready && res_valid;
    assign out_valid = valid_reg;
    assign out_item  = buf_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_fire && buf_reg[0].last_column)
        begin
            valid_reg <= 1'b0;
        end
    end

    // column results shift toward slot 0
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                buf_reg[i] <= res[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < NUM_COLUMNS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

endmodule

// ===== design/altitude_rolling_digits.sv =====
// Rolling-drum altitude readout.
// Slave stream: one item per altitude word, tdata[14:0] = altitude_code
// (tens of feet times 8 plus a 3-bit fraction of 10 ft).
// Master stream: four items per word, columns 0 (tens) to 3 (ten thousands)
// in order, tlast on column 3. Each carries a scroll offset (2000 = rest)
// and three digit codes (above, middle, below; 10 = blank).
// The accepted word is registered in the decoder and then loaded into the
// column buffer once the buffer is free; columns then leave one per cycle
// while tready is high.
// The single result channel carries four columns per word; the next word
// is taken and decoded while the current columns drain.
// Reset clears both valid flags; no item is pending afterwards.
// When the receiver stalls, the current column holds on tdata, the next
// word waits in the input register, and s_axis_tready drops once that
// register is full.
module altitude_rolling_digits
    import ard_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [14:0] altitude_code, [15] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [1:0] column, [13:2] scroll_offset,
                                                  // [17:14] digit_above, [21:18] digit_middle,
                                                  // [25:22] digit_below, [31:26] zero
    output logic                   m_axis_tlast
);

    logic        res_valid;
    logic        res_ready;
    result_set_t res;
    result_t     out_item;

    ard_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .altitude_code (s_axis_tdata[14:0]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    ard_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {6'd0, out_item.digit_below, out_item.digit_middle,
                           out_item.digit_above, out_item.scroll_offset, out_item.column};
    assign m_axis_tlast = out_item.last_column;

endmodule

// ===== design/ard_checker.sv =====
module ard_checker
    import ard_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[1:0] == COL_TEN_THOUSANDS) == m_axis_tlast))
        else $error("tlast does not match final column");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1)
        else $error("column sequence broken");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:14] <= BLANK_CODE && m_axis_tdata[21:18] <= BLANK_CODE
                          && m_axis_tdata[25:22] <= BLANK_CODE)
        else $error("digit code out of range");

endmodule

bind altitude_rolling_digits ard_checker u_ard_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
